// ===== rtl/sadp_pkg.sv =====
// ----------------------------------------------------------------------------
// sadp_pkg
// Shared constants, tables and types of the spiral-arm density perturbation.
// ----------------------------------------------------------------------------
package sadp_pkg;

   localparam int FB        = 16;   // fraction bits of radius and results
   localparam int AB        = 16;   // angle bits, 2^-AB turn units
   localparam int LOGF      = 24;   // fraction bits of log2
   localparam int MAX_POWER = 10;
   localparam int LOG_CELLS = LOGF;
   localparam int SIN_TERMS = 4;

   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
   localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054A;
   localparam logic [31:0] PI_Q30     = 32'd3373259426;

   // Taylor divisors of sin, innermost first, and floor(2^32/d)
   localparam logic [6:0]  TAYLOR_DIV   [0:SIN_TERMS-1] = '{7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [31:0] TAYLOR_RECIP [0:SIN_TERMS-1] =
      '{32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};

   typedef enum logic [2:0] {
      REG_ARM_COUNT  = 3'd0,
      REG_INV_TAN    = 3'd1,
      REG_LOG_REF    = 3'd2,
      REG_PHASE_OFF  = 3'd3,
      REG_ARM_WEIGHT = 3'd4,
      REG_POWER_IDX  = 3'd5,
      REG_NORM       = 3'd6,
      REG_UNUSED     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [30:0] x;    // angle, Q30
      logic [31:0] x2;   // angle squared, Q30
      logic [30:0] a;    // running Horner term, Q30
   } taylor_type;

endpackage

// ===== rtl/sadp_log_cell.sv =====
// ----------------------------------------------------------------------------
// sadp_log_cell
// One bit of log2: squares the Q1.30 mantissa and shifts one fraction bit in.
// ----------------------------------------------------------------------------
module sadp_log_cell (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] m_in,
   input  logic [23:0] frac_in,
   input  logic [4:0]  exp_in,
   output logic [30:0] m_out,
   output logic [23:0] frac_out,
   output logic [4:0]  exp_out
);
   import sadp_pkg::*;

   logic [61:0] sq;
   logic [31:0] sq_sh;
   logic [30:0] m_ff, m_in_nx;
   logic [23:0] frac_ff;
   logic [4:0]  exp_ff;

   assign sq    = 62'(m_in) * 62'(m_in);
   assign sq_sh = sq[61:30];
   assign m_in_nx = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= m_in_nx;
         frac_ff <= {frac_in[22:0], sq_sh[31]};
         exp_ff  <= exp_in;
      end
   end

   assign m_out    = m_ff;
   assign frac_out = frac_ff;
   assign exp_out  = exp_ff;
endmodule

// ===== rtl/sadp_taylor_cell.sv =====
// ----------------------------------------------------------------------------
// sadp_taylor_cell
// One Horner step of the sine series: a' = 1 - (x2*a)/d, over three stages.
// ----------------------------------------------------------------------------
module sadp_taylor_cell (
   input  logic                 clock,
   input  logic                 en,
   input  logic [6:0]           div,
   input  logic [31:0]          recip,
   input  sadp_pkg::taylor_type t_in,
   output sadp_pkg::taylor_type t_out
);
   import sadp_pkg::*;

   logic [62:0] va;
   logic [63:0] vq;
   logic [38:0] qd;
   logic [31:0] rem;
   logic [31:0] q;
   taylor_type  s1_ff, s2_ff, s3_ff;
   logic [31:0] v1_ff, v2_ff, q2_ff;

   assign va  = 63'(t_in.x2) * 63'(t_in.a);
   assign vq  = 64'(v1_ff) * 64'(recip);
   // reciprocal quotient is low by at most one
   assign qd  = 39'(q2_ff) * 39'(div);
   assign rem = v2_ff - qd[31:0];
   assign q   = (rem >= 32'(div)) ? q2_ff + 32'd1 : q2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= t_in;
         v1_ff <= va[61:30];
         s2_ff <= s1_ff;
         v2_ff <= v1_ff;
         q2_ff <= vq[63:32];
         s3_ff.x  <= s2_ff.x;
         s3_ff.x2 <= s2_ff.x2;
         s3_ff.a  <= Q30_ONE - q[30:0];
      end
   end

   assign t_out = s3_ff;
endmodule

// ===== rtl/sadp_power_cell.sv =====
// ----------------------------------------------------------------------------
// sadp_power_cell
// One factor of s^N: multiplies the running power by s when the cell is in use.
// ----------------------------------------------------------------------------
module sadp_power_cell (
   input  logic        clock,
   input  logic        en,
   input  logic        use_cell,
   input  logic [30:0] s_in,
   input  logic [30:0] p_in,
   output logic [30:0] s_out,
   output logic [30:0] p_out
);
   import sadp_pkg::*;

   logic [61:0] prod;
   logic [30:0] s_ff, p_ff;

   assign prod = 62'(p_in) * 62'(s_in);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
         p_ff <= use_cell ? prod[60:30] : p_in;
      end
   end

   assign s_out = s_ff;
   assign p_out = p_ff;
endmodule

// ===== rtl/spiral_arm_density_perturbation.sv =====
// ----------------------------------------------------------------------------
// spiral_arm_density_perturbation
// Logarithmic spiral-arm density factor, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: positions enter on the req_ stream (radius, azimuth) and one density
// factor leaves on the rsp_ stream for each item, in order. Registers are set
// over the csr_ APB port; they are to be set only while the stream is idle,
// which the block itself does not enforce; pready is always high. One item is
// taken every cycle while the output is not stalled. The depth is set by the
// chain of cells: one log2 bit cell per fraction bit (24), four three-stage
// sine Horner cells, ten power cells, and the stages of the wide phase product.
// All stages advance together: when rsp_tvalid is high and rsp_tready low the
// whole pipeline holds and req_tready drops; the output register keeps its
// item. Reset empties the pipeline and loads the register defaults
// (two arms, index one, unit weight, C = 2).
// ----------------------------------------------------------------------------
module spiral_arm_density_perturbation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // radius[31:0], azimuth[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // density_factor[19:0], zero[23:20]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sadp_pkg::*;

   localparam int DEPTH = 61;

   // ---------------- configuration ----------------
   logic [3:0]  arm_ff;
   logic [23:0] inv_ff;
   logic [23:0] lref_ff;
   logic [15:0] poff_ff;
   logic [16:0] wgt_ff;
   logic [3:0]  pidx_ff;
   logic [18:0] norm_ff;
   reg_index_type widx, ridx;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr   = csr_psel & csr_penable & csr_pwrite;
   assign widx = reg_index_type'(csr_paddr[4:2]);
   assign ridx = widx;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff  <= 4'd2;
         inv_ff  <= 24'd180041;
         lref_ff <= 24'd0;
         poff_ff <= 16'd0;
         wgt_ff  <= 17'd65536;
         pidx_ff <= 4'd1;
         norm_ff <= 19'd131072;
      end else if (wr) begin
         unique case (widx)
            REG_ARM_COUNT:  arm_ff  <= csr_pwdata[3:0];
            REG_INV_TAN:    inv_ff  <= csr_pwdata[23:0];
            REG_LOG_REF:    lref_ff <= csr_pwdata[23:0];
            REG_PHASE_OFF:  poff_ff <= csr_pwdata[15:0];
            REG_ARM_WEIGHT: wgt_ff  <= csr_pwdata[16:0];
            REG_POWER_IDX:  pidx_ff <= csr_pwdata[3:0];
            REG_NORM:       norm_ff <= csr_pwdata[18:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_ARM_COUNT:  csr_prdata = {28'd0, arm_ff};
         REG_INV_TAN:    csr_prdata = {8'd0, inv_ff};
         REG_LOG_REF:    csr_prdata = {8'd0, lref_ff};
         REG_PHASE_OFF:  csr_prdata = {16'd0, poff_ff};
         REG_ARM_WEIGHT: csr_prdata = {15'd0, wgt_ff};
         REG_POWER_IDX:  csr_prdata = {28'd0, pidx_ff};
         REG_NORM:       csr_prdata = {13'd0, norm_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------- flow control ----------------
   logic             en;
   logic [DEPTH-1:0] v_ff;

   assign en         = ~v_ff[DEPTH-1] | rsp_tready;
   assign req_tready = en & ~reset;
   assign rsp_tvalid = v_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[DEPTH-2:0], req_tvalid & req_tready};
   end

   // ---------------- normalise ----------------
   logic [31:0] r;
   logic [15:0] az;
   logic [4:0]  e;
   logic [30:0] m0;

   assign r  = (req_tdata[31:0] == 32'd0) ? 32'd1 : req_tdata[31:0];
   assign az = req_tdata[47:32];

   always_comb begin
      e = 5'd0;
      for (int i = 0; i < 32; i++) if (r[i]) e = 5'(i);
   end
   assign m0 = (e == 5'd31) ? r[31:1] : 31'(r << (5'd30 - e));

   logic [30:0] m_w    [0:LOG_CELLS];
   logic [23:0] frac_w [0:LOG_CELLS];
   logic [4:0]  exp_w  [0:LOG_CELLS];
   logic [15:0] az_ff  [0:31];
   logic [30:0] m0_ff;
   logic [4:0]  e0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff    <= m0;
         e0_ff    <= e;
         az_ff[0] <= az;
         for (int i = 1; i < 32; i++) az_ff[i] <= az_ff[i-1];
      end
   end

   assign m_w[0]    = m0_ff;
   assign frac_w[0] = 24'd0;
   assign exp_w[0]  = e0_ff;

   for (genvar g = 0; g < LOG_CELLS; g++) begin : g_log
      sadp_log_cell u_cell (
         .clock(clock), .en(en),
         .m_in(m_w[g]), .frac_in(frac_w[g]), .exp_in(exp_w[g]),
         .m_out(m_w[g+1]), .frac_out(frac_w[g+1]), .exp_out(exp_w[g+1])
      );
   end

   // ---------------- ln and phase ----------------
   logic [29:0] lg;
   logic        lg_neg;
   logic [28:0] lg_mag;
   logic [60:0] ln_prod;
   logic        ln_neg_ff;
   logic [28:0] ln_mag_ff;

   assign lg      = {1'b0, exp_w[LOG_CELLS], frac_w[LOG_CELLS]} - (30'd16 << LOGF);
   assign lg_neg  = lg[29];
   assign lg_mag  = lg_neg ? 29'(30'd0 - lg) : lg[28:0];
   assign ln_prod = 61'(lg_mag) * 61'(LN2_Q32);

   logic [33:0] ln34, lr34, lrel;
   logic        rel_neg_ff;
   logic [32:0] rel_mag_ff;

   assign ln34 = ln_neg_ff ? 34'd0 - {5'd0, ln_mag_ff} : {5'd0, ln_mag_ff};
   assign lr34 = {{2{lref_ff[23]}}, lref_ff, 8'd0};
   assign lrel = ln34 - lr34;

   logic [56:0] pm_ff;
   logic        neg_ff [0:3];
   logic [28:0] ml;
   logic [27:0] mh;
   logic [103:0] acc1_ff, acc2_ff, acc3_ff, acc_fin;
   logic [28:0] ml_ff;
   logic [27:0] mh_ff [0:2];
   logic [15:0] turns_ff;

   assign ml = pm_ff[28:0];
   assign mh = pm_ff[56:29];
   assign acc_fin = acc3_ff + (104'(60'(mh_ff[2]) * 60'(INV2PI_Q64[63:32])) << 61);

   logic [15:0] tq, dt, u;
   logic [19:0] um;
   logic [16:0] tfold;
   logic [15:0] t_ff;

   assign tq    = neg_ff[3] ? 16'd0 - acc_fin[103:88] : acc_fin[103:88];
   assign dt    = turns_ff + poff_ff - az_ff[31];
   assign um    = 20'(arm_ff) * 20'(dt);
   assign u     = um[15:0] + (16'd1 << (AB - 2));
   assign tfold = (u <= (16'd1 << (AB - 1))) ? {1'b0, u} : 17'h10000 - 17'(u);

   always_ff @(posedge clock) begin
      if (en) begin
         ln_neg_ff  <= lg_neg;
         ln_mag_ff  <= ln_prod[60:32];
         rel_neg_ff <= lrel[33];
         rel_mag_ff <= lrel[33] ? 33'(34'd0 - lrel) : lrel[32:0];
         pm_ff      <= 57'(rel_mag_ff) * 57'(inv_ff);
         neg_ff[0]  <= rel_neg_ff;
         for (int i = 1; i < 4; i++) neg_ff[i] <= neg_ff[i-1];
         acc1_ff  <= 104'(61'(ml) * 61'(INV2PI_Q64[31:0]));
         ml_ff    <= ml;
         mh_ff[0] <= mh;
         acc2_ff  <= acc1_ff + (104'(61'(ml_ff) * 61'(INV2PI_Q64[63:32])) << 32);
         mh_ff[1] <= mh_ff[0];
         acc3_ff  <= acc2_ff + (104'(60'(mh_ff[1]) * 60'(INV2PI_Q64[31:0])) << 29);
         mh_ff[2] <= mh_ff[1];
         turns_ff <= tq;
         t_ff     <= tfold[15:0];
      end
   end

   // ---------------- sine ----------------
   logic [47:0] xp;
   logic [30:0] x_ff, xs_ff;
   logic [61:0] xx;
   logic [31:0] x2_ff;
   taylor_type  tw [0:SIN_TERMS];

   assign xp = 48'(t_ff) * 48'(PI_Q30);
   assign xx = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= xp[46:16];
         xs_ff <= x_ff;
         x2_ff <= xx[61:30];
      end
   end

   assign tw[0] = '{x: xs_ff, x2: x2_ff, a: Q30_ONE};

   for (genvar g = 0; g < SIN_TERMS; g++) begin : g_sin
      sadp_taylor_cell u_cell (
         .clock(clock), .en(en),
         .div(TAYLOR_DIV[g]), .recip(TAYLOR_RECIP[g]),
         .t_in(tw[g]), .t_out(tw[g+1])
      );
   end

   logic [61:0] sx, sq;
   logic [30:0] sn_ff, s_ff;

   assign sx = 62'(tw[SIN_TERMS].x) * 62'(tw[SIN_TERMS].a);
   assign sq = 62'(sn_ff) * 62'(sn_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff <= (sx[61:30] > 32'(Q30_ONE)) ? Q30_ONE : sx[60:30];
         s_ff  <= sq[60:30];
      end
   end

   // ---------------- power chain ----------------
   logic [3:0]  n_eff;
   logic [30:0] ps_w [0:MAX_POWER];
   logic [30:0] pp_w [0:MAX_POWER];

   assign n_eff = (pidx_ff > 4'(MAX_POWER)) ? 4'(MAX_POWER) : pidx_ff;
   assign ps_w[0] = s_ff;
   assign pp_w[0] = Q30_ONE;

   for (genvar g = 0; g < MAX_POWER; g++) begin : g_pow
      sadp_power_cell u_cell (
         .clock(clock), .en(en), .use_cell(4'(g) < n_eff),
         .s_in(ps_w[g]), .p_in(pp_w[g]),
         .s_out(ps_w[g+1]), .p_out(pp_w[g+1])
      );
   end

   // ---------------- mix and saturate ----------------
   logic [16:0] w;
   logic [35:0] wn;
   logic [19:0] wc_ff;
   logic [30:0] pf_ff;
   logic [50:0] wp;
   logic [21:0] sum;
   logic [19:0] out_ff;

   assign w   = (wgt_ff > 17'h10000) ? 17'h10000 : wgt_ff;
   assign wn  = 36'(w) * 36'(norm_ff);
   assign wp  = 51'(wc_ff) * 51'(pf_ff);
   assign sum = 22'(17'h10000 - w) + 22'(wp[50:30]);

   always_ff @(posedge clock) begin
      if (en) begin
         wc_ff  <= wn[35:16];
         pf_ff  <= pp_w[MAX_POWER];
         out_ff <= (sum > 22'hFFFFF) ? 20'hFFFFF : sum[19:0];
      end
   end

   assign rsp_tdata = {4'd0, out_ff};
endmodule

// ===== test/sadp_checker.sv =====
// ----------------------------------------------------------------------------
// sadp_checker
// Watches the position and density streams and the register port, predicts
// each density factor and compares it in order with what the block returns.
// ----------------------------------------------------------------------------
module sadp_checker
   import sadp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,    // radius[31:0], azimuth[47:32]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // density_factor[19:0], zero[23:20]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [3:0]  arm_count;
   logic [23:0] inv_tan;
   logic [23:0] log_ref;
   logic [15:0] phase_off;
   logic [16:0] arm_weight;
   logic [3:0]  power_idx;
   logic [18:0] norm;

   logic [19:0] density_q[$];

   function automatic logic [19:0] predict_density(logic [31:0] radius, logic [15:0] az);
      longint unsigned r, m, frac, mag, turns, dt, u, t, x, x2, a, sn, s, p, w, wc, sum, n;
      longint          lg, ln, lr0, lrel;
      logic [127:0]    prod;
      int              e;
      r = (radius == 0) ? 1 : radius;
      e = 31;
      while (e > 0 && r[e] == 1'b0) e--;
      m = (e <= 30) ? (r << (30 - e)) : (r >> 1);
      frac = 0;
      for (int i = 0; i < LOGF; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      lg = longint'((longint'(e) << LOGF) | frac) - (longint'(FB) << LOGF);
      mag = (lg < 0) ? -lg : lg;
      mag = (mag * LN2_Q32) >> 32;
      ln = (lg < 0) ? -longint'(mag) : longint'(mag);
      lr0 = {{40{log_ref[23]}}, log_ref};
      lrel = ln - lr0 * 256;
      mag = (lrel < 0) ? -lrel : lrel;
      mag = mag * inv_tan;
      prod = {64'd0, mag} * {64'd0, INV2PI_Q64};
      turns = prod[103:88];
      if (lrel < 0) turns = (0 - turns) & 16'hFFFF;
      dt = (turns + phase_off - az) & 16'hFFFF;
      u = (arm_count * dt + 64'h4000) & 16'hFFFF;
      t = (u <= 64'h8000) ? u : 64'h10000 - u;
      // Taylor sine, Horner form, clamped at one
      x = (t * PI_Q30) >> 16;
      x2 = (x * x) >> 30;
      a = 64'h4000_0000 - ((x2 * 64'h4000_0000) >> 30) / 72;
      a = 64'h4000_0000 - ((x2 * a) >> 30) / 42;
      a = 64'h4000_0000 - ((x2 * a) >> 30) / 20;
      a = 64'h4000_0000 - ((x2 * a) >> 30) / 6;
      sn = (x * a) >> 30;
      if (sn > 64'h4000_0000) sn = 64'h4000_0000;
      s = (sn * sn) >> 30;
      n = (power_idx > MAX_POWER) ? MAX_POWER : power_idx;
      p = 64'h4000_0000;
      for (int i = 0; i < n; i++) p = (p * s) >> 30;
      w = (arm_weight > 17'h10000) ? 64'h10000 : arm_weight;
      wc = (w * norm) >> FB;
      sum = (64'h10000 - w) + ((wc * p) >> 30);
      return (sum > 64'hF_FFFF) ? 20'hF_FFFF : sum[19:0];
   endfunction

   assign open_count = density_q.size();

   always @(posedge clock) begin
      if (reset) begin
         arm_count  <= 4'd2;
         inv_tan    <= 24'd180041;
         log_ref    <= '0;
         phase_off  <= '0;
         arm_weight <= 17'd65536;
         power_idx  <= 4'd1;
         norm       <= 19'd131072;
         density_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_ARM_COUNT:  arm_count  <= csr_pwdata[3:0];
               REG_INV_TAN:    inv_tan    <= csr_pwdata[23:0];
               REG_LOG_REF:    log_ref    <= csr_pwdata[23:0];
               REG_PHASE_OFF:  phase_off  <= csr_pwdata[15:0];
               REG_ARM_WEIGHT: arm_weight <= csr_pwdata[16:0];
               REG_POWER_IDX:  power_idx  <= csr_pwdata[3:0];
               REG_NORM:       norm       <= csr_pwdata[18:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            density_q.push_back(predict_density(req_tdata[31:0], req_tdata[47:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (density_q.size() == 0) begin
               $error("density_factor: unexpected item, actual %0d", rsp_tdata[19:0]);
               fail_count <= fail_count + 1;
            end else begin
               logic [19:0] want;
               want = density_q.pop_front();
               if (rsp_tdata[19:0] !== want) begin
                  $error("density_factor: expected %0d actual %0d", want, rsp_tdata[19:0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives positions and register settings into the spiral-arm density block
// under several idle and back-pressure patterns; the checker scores results.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sadp_pkg::*;

   localparam int WATCHDOG = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // radius[31:0], azimuth[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // density_factor[19:0], zero[23:20]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int open_count;
   int idle_pct;
   int stall_pct;
   int positions;
   int settings;
   int quiet;

   spiral_arm_density_perturbation u_dut (.*);

   sadp_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_position(input logic [31:0] radius, input logic [15:0] az);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {az, radius};
      do @(posedge clock); while (!req_tready);
      positions++;
   endtask

   // wait for the pipeline to empty before touching the registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (open_count != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic random_setting(input int kind);
      logic [31:0] v[7];
      v[0] = $urandom_range(15);
      v[1] = $urandom & 32'hFF_FFFF;
      v[2] = $urandom & 32'hFF_FFFF;
      v[3] = $urandom & 32'hFFFF;
      v[4] = ($urandom_range(3) == 0) ? $urandom & 32'h1_FFFF : $urandom_range(65536);
      v[5] = $urandom_range(15);
      v[6] = $urandom_range(65536, 393216);
      if (kind == 1) begin
         v = '{32'hF, 32'hFF_FFFF, 32'h7F_FFFF, 32'hFFFF, 32'h1_FFFF, 32'hF, 32'h7_FFFF};
      end else if (kind == 2) begin
         v = '{32'h1, 32'h0, 32'h80_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000};
      end
      for (int i = 0; i < 7; i++) csr_write(reg_index_type'(i), v[i]);
      csr_write(REG_UNUSED, $urandom);
      settings++;
   endtask

   function automatic logic [31:0] pick_radius();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(255);
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom >> $urandom_range(31);
      endcase
   endfunction

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      positions   = 0;
      settings    = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: radius and azimuth extremes
      send_position(32'h0, 16'h0);
      send_position(32'h1, 16'hFFFF);
      send_position(32'hFFFF_FFFF, 16'h8000);
      send_position(32'h1_0000, 16'h4000);
      send_position(32'h8000_0000, 16'h0);
      send_position(32'h0000_FFFF, 16'hC000);
      send_position(32'h5555_AAAA, 16'h5A5A);
      send_position(32'hAAAA_5555, 16'hA5A5);
      drain();

      // zero arms, zero index, weight above one
      csr_write(REG_ARM_COUNT, 32'h0);
      csr_write(REG_POWER_IDX, 32'h0);
      csr_write(REG_ARM_WEIGHT, 32'h1_FFFF);
      send_position(32'h0, 16'h1234);
      send_position(32'hFFFF_FFFF, 16'hFFFF);
      send_position(32'h0001_8000, 16'h0);
      drain();
      // index above the maximum, negative reference log
      csr_write(REG_ARM_COUNT, 32'hF);
      csr_write(REG_POWER_IDX, 32'hF);
      csr_write(REG_LOG_REF, 32'h80_0000);
      csr_write(REG_ARM_WEIGHT, 32'h1_0000);
      csr_write(REG_NORM, 32'h7_FFFF);
      for (int i = 0; i < 6; i++) send_position(pick_radius(), 16'($urandom));
      drain();
      settings += 2;

      for (int ph = 0; ph < 12; ph++) begin
         random_setting(ph < 2 ? ph + 1 : 0);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 23; stall_pct = 23; end
         endcase
         for (int i = 0; i < 150; i++) send_position(pick_radius(), 16'($urandom));
         drain();
      end

      $display("Checked %0d positions across %0d register settings,", positions, settings);
      $display("with sender gaps and receiver back-pressure in turn.");
      if (fail_count == 0 && open_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sadp_pkg.sv
rtl/sadp_log_cell.sv
rtl/sadp_taylor_cell.sv
rtl/sadp_power_cell.sv
rtl/spiral_arm_density_perturbation.sv
test/sadp_checker.sv
test/tb_top.sv
